FILE: hw/rtl/swmac_pkg.sv
package swmac_pkg;

    localparam int WINDOW_MAX_DEFAULT  = 64;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int CFG_BITS            = 7;
    localparam int IN_FIELD_BITS       = 16;
    localparam int IN_TDATA_BITS       = 16;
    localparam int COST_BITS           = 22;
    localparam int OUT_TDATA_BITS      = 24;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_REMOVE,
        OP_INSERT,
        OP_LOAD,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     valid;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/sliding_window_median_abs_cost_core.sv
// Flow: no result while the window fills; words after that first remove the
// oldest sample from the sorted cell row. The word that fills the window and
// every later word give a result by a scan of k cells through the head cell,
// k = effective window size; a new word is taken only once the last is through.
// Reset: rst_n asynchronous active low; window size returns to 1, fill count
// and write pointer to 0, output empty. Sample stores are not cleared.
module sliding_window_median_abs_cost_core #(
    parameter int WINDOW_MAX  = swmac_pkg::WINDOW_MAX_DEFAULT,
    parameter int SAMPLE_BITS = swmac_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swmac_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swmac_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,  // [15:0] sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [swmac_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata  // [21:0] cost
);
    import swmac_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int ACC_W  = SAMPLE_BITS + CNT_W + 1;
    localparam int WIDE_W = ACC_W + COST_BITS;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CFG_BITS-1:0]      ws_reg, ws_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [PTR_W-1:0]         wp_reg, wp_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     tvalid_reg, tvalid_next;
    logic [COST_BITS-1:0]     cost_reg, cost_next;

    logic [SAMPLE_BITS-1:0]   ring_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]   old_reg;
    logic [SAMPLE_BITS-1:0]   s_reg;
    logic [SAMPLE_BITS-1:0]   s_in;

    logic [CNT_W-1:0]         k;
    logic [CNT_W-1:0]         mid;
    logic                     full;
    logic [CNT_W-1:0]         n_ins;
    logic [CNT_W-1:0]         n_inc;
    logic                     accept;
    cell_op_t                 chain_op;
    logic [CNT_W-1:0]         chain_cnt;
    logic [SAMPLE_BITS-1:0]   chain_key;
    logic [SAMPLE_BITS-1:0]   head_shadow;
    logic signed [ACC_W-1:0]  v_ext;
    logic [WIDE_W-1:0]        acc_wide;
    logic [COST_BITS-1:0]     cost_sat;

    assign s_in   = SAMPLE_BITS'(s_axis_tdata[IN_FIELD_BITS-1:0]);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (ws_reg == '0)
        begin
            k = CNT_W'(1);
        end
        else if (32'(ws_reg) > WINDOW_MAX)
        begin
            k = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k = CNT_W'(ws_reg);
        end
    end

    assign mid   = (k - CNT_W'(1)) >> 1;
    assign full  = (fill_reg == k);
    assign n_ins = full ? (k - CNT_W'(1)) : fill_reg;
    assign n_inc = n_ins + CNT_W'(1);

    assign v_ext    = signed'(ACC_W'(head_shadow));
    assign acc_wide = WIDE_W'(unsigned'(acc_reg));
    assign cost_sat = (acc_wide > WIDE_W'(COST_MAX)) ? COST_MAX : COST_BITS'(acc_wide);

    always_comb
    begin
        unique case (state_reg)
            ST_REMOVE: chain_op = OP_REMOVE;
            ST_INSERT: chain_op = OP_INSERT;
            ST_LOAD:   chain_op = OP_LOAD;
            ST_SCAN:   chain_op = OP_SHIFT;
            default:   chain_op = OP_HOLD;
        endcase
    end

    assign chain_cnt = (state_reg == ST_REMOVE) ? k : n_ins;
    assign chain_key = (state_reg == ST_REMOVE) ? old_reg : s_reg;

    swmac_chain #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk         (clk),
        .op          (chain_op),
        .cnt         (chain_cnt),
        .key         (chain_key),
        .head_shadow (head_shadow)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wp_reg] <= s_in;
            old_reg          <= ring_mem[wp_reg];
            s_reg            <= s_in;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ws_next     = ws_reg;
        fill_next   = fill_reg;
        wp_next     = wp_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        tvalid_next = tvalid_reg && !m_axis_tready;
        cost_next   = cost_reg;

        if (cfg_we)
        begin
            ws_next   = cfg_wdata;
            fill_next = '0;
            wp_next   = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = full ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                fill_next  = n_inc;
                wp_next    = ((CNT_W'(wp_reg) + CNT_W'(1)) == k) ? '0 : wp_reg + PTR_W'(1);
                state_next = (n_inc == k) ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                acc_next   = '0;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg > mid)
                begin
                    acc_next = acc_reg + v_ext;
                end
                else if ((idx_reg < mid) || !k[0])
                begin
                    acc_next = acc_reg - v_ext;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == k - CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!tvalid_reg || m_axis_tready)
                begin
                    tvalid_next = 1'b1;
                    cost_next   = cost_sat;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ws_reg     <= CFG_BITS'(1);
            fill_reg   <= '0;
            wp_reg     <= '0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            tvalid_reg <= 1'b0;
            cost_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ws_reg     <= ws_next;
            fill_reg   <= fill_next;
            wp_reg     <= wp_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            tvalid_reg <= tvalid_next;
            cost_reg   <= cost_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_BITS - COST_BITS)'(0), cost_reg};

endmodule

FILE: hw/rtl/swmac_cell.sv
module swmac_cell #(
    parameter int SAMPLE_BITS = swmac_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  swmac_pkg::cell_ctrl_t  ctrl,
    input  logic [SAMPLE_BITS-1:0] key,
    input  logic [SAMPLE_BITS-1:0] low_value,
    input  logic                   low_big,
    input  logic [SAMPLE_BITS-1:0] up_value,
    input  logic [SAMPLE_BITS-1:0] up_shadow,
    output logic [SAMPLE_BITS-1:0] value,
    output logic                   big,
    output logic [SAMPLE_BITS-1:0] shadow
);
    import swmac_pkg::*;

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;
    logic [SAMPLE_BITS-1:0] shadow_reg;
    logic [SAMPLE_BITS-1:0] shadow_next;

    assign big    = !ctrl.valid || (value_reg > key);
    assign value  = value_reg;
    assign shadow = shadow_reg;

    always_comb
    begin
        value_next  = value_reg;
        shadow_next = shadow_reg;
        case (ctrl.op)
            OP_REMOVE:
            begin
                if (ctrl.valid && (value_reg >= key))
                begin
                    value_next = up_value;
                end
            end
            OP_INSERT:
            begin
                if (big)
                begin
                    value_next = low_big ? low_value : key;
                end
            end
            OP_LOAD:  shadow_next = value_reg;
            OP_SHIFT: shadow_next = up_shadow;
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        shadow_reg <= shadow_next;
    end

endmodule

FILE: hw/rtl/swmac_chain.sv
module swmac_chain #(
    parameter int WINDOW_MAX  = swmac_pkg::WINDOW_MAX_DEFAULT,
    parameter int SAMPLE_BITS = swmac_pkg::SAMPLE_BITS_DEFAULT,
    parameter int CNT_W       = $clog2(WINDOW_MAX + 1)
) (
    input  logic                   clk,
    input  swmac_pkg::cell_op_t    op,
    input  logic [CNT_W-1:0]       cnt,
    input  logic [SAMPLE_BITS-1:0] key,
    output logic [SAMPLE_BITS-1:0] head_shadow
);
    import swmac_pkg::*;

    logic [SAMPLE_BITS-1:0] value_w  [WINDOW_MAX];
    logic                   big_w    [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] shadow_w [WINDOW_MAX];
    cell_ctrl_t             ctrl_w   [WINDOW_MAX];

    assign head_shadow = shadow_w[0];

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] low_value;
        logic                   low_big;
        logic [SAMPLE_BITS-1:0] up_value;
        logic [SAMPLE_BITS-1:0] up_shadow;

        assign ctrl_w[i].op    = op;
        assign ctrl_w[i].valid = (CNT_W'(i) < cnt);

        if (i == 0)
        begin : g_low_edge
            assign low_value = '0;
            assign low_big   = 1'b0;
        end
        else
        begin : g_low
            assign low_value = value_w[i-1];
            assign low_big   = big_w[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_up_edge
            assign up_value  = '0;
            assign up_shadow = '0;
        end
        else
        begin : g_up
            assign up_value  = value_w[i+1];
            assign up_shadow = shadow_w[i+1];
        end

        swmac_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl_w[i]),
            .key       (key),
            .low_value (low_value),
            .low_big   (low_big),
            .up_value  (up_value),
            .up_shadow (up_shadow),
            .value     (value_w[i]),
            .big       (big_w[i]),
            .shadow    (shadow_w[i])
        );
    end

endmodule

FILE: hw/rtl/swmac_checker.sv
module swmac_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [swmac_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
    import swmac_pkg::*;

    logic in_word;

    assign in_word = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_word |=> !s_axis_tready)
        else $error("input ready straight after an accepted word");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised while input side idle");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_word |=> !$rose(m_axis_tvalid))
        else $error("result raised one cycle after accept");

endmodule

bind sliding_window_median_abs_cost_core swmac_checker u_swmac_checker (.*);
